### rtl/mdp_pkg.sv
// Shared types and constants for the microinstruction datapath step.
package mdp_pkg;

   localparam int MEM_WORDS = 256;
   localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int DATA_W    = 32;
   localparam int NUM_REGS  = 9;
   localparam int REQ_W     = 24;
   localparam int RSP_W     = 136;
   localparam int MBR_W     = 8;

   // register file slots, same order as the C-bus mask bits
   localparam int REG_MAR = 0;
   localparam int REG_MDR = 1;
   localparam int REG_PC  = 2;
   localparam int REG_SP  = 3;
   localparam int REG_LV  = 4;
   localparam int REG_CPP = 5;
   localparam int REG_TOS = 6;
   localparam int REG_OPC = 7;
   localparam int REG_H   = 8;

   typedef enum logic [1:0] {
      FUNC_AND  = 2'd0,
      FUNC_OR   = 2'd1,
      FUNC_NOTB = 2'd2,
      FUNC_ADD  = 2'd3
   } alu_func_type;

   // codes 8 to 15 all select OPC
   typedef enum logic [3:0] {
      BSEL_MDR    = 4'd0,
      BSEL_PC     = 4'd1,
      BSEL_MBR_SX = 4'd2,
      BSEL_MBR_ZX = 4'd3,
      BSEL_SP     = 4'd4,
      BSEL_LV     = 4'd5,
      BSEL_CPP    = 4'd6,
      BSEL_TOS    = 4'd7
   } bsel_type;

   // one microinstruction, laid out as on the request tdata (lowest field last)
   typedef struct packed {
      logic [3:0]   b_select;
      logic         mem_read;
      logic         mem_write;
      logic [8:0]   c_write_mask;
      logic         carry_in;
      logic         invert_a;
      logic         enable_b;
      logic         enable_a;
      alu_func_type func;
      logic         shift_right1;
      logic         shift_left8;
   } uinstr_type;

   typedef struct packed {
      logic [DATA_W-1:0] shifter_out;
      logic              carry_out;
      logic              negative;
      logic              zero;
   } alu_res_type;

endpackage

### rtl/mdp_alu.sv
// ALU and shifter of the datapath: operand gating, logic/add functions, shifts and flags.
module mdp_alu (
   input  mdp_pkg::uinstr_type         ctl,
   input  logic [mdp_pkg::DATA_W-1:0]  a_bus,
   input  logic [mdp_pkg::DATA_W-1:0]  b_bus,
   output mdp_pkg::alu_res_type        res
);

   logic [mdp_pkg::DATA_W-1:0] opa;
   logic [mdp_pkg::DATA_W-1:0] opb;
   logic [mdp_pkg::DATA_W-1:0] alu_out;
   logic [mdp_pkg::DATA_W-1:0] sh8;
   logic [mdp_pkg::DATA_W-1:0] sh_out;
   logic [mdp_pkg::DATA_W:0]   sum;
   logic                       carry;

   always_comb begin
      opa = ctl.enable_a ? (ctl.invert_a ? ~a_bus : a_bus) : '0;
      opb = ctl.enable_b ? b_bus : '0;
      sum = {1'b0, opa} + {1'b0, opb} + (mdp_pkg::DATA_W+1)'(ctl.carry_in);
      carry = 1'b0;
      case (ctl.func)
         mdp_pkg::FUNC_AND:  alu_out = opa & opb;
         mdp_pkg::FUNC_OR:   alu_out = opa | opb;
         mdp_pkg::FUNC_NOTB: alu_out = ~opb;
         mdp_pkg::FUNC_ADD: begin
            alu_out = sum[mdp_pkg::DATA_W-1:0];
            carry   = sum[mdp_pkg::DATA_W];
         end
         default: alu_out = '0;
      endcase
      sh8    = ctl.shift_left8 ? {alu_out[mdp_pkg::DATA_W-9:0], 8'h00} : alu_out;
      sh_out = ctl.shift_right1 ? {sh8[mdp_pkg::DATA_W-1], sh8[mdp_pkg::DATA_W-1:1]} : sh8;
      res.shifter_out = sh_out;
      res.carry_out   = carry;
      res.negative    = sh_out[mdp_pkg::DATA_W-1];
      res.zero        = (sh_out == '0);
   end

endmodule

### rtl/mdp_dmem.sv
// Data memory: up to one write and one registered read per cycle, entries read as zero until written.
module mdp_dmem (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic                       rd_en,
   input  logic [mdp_pkg::MEM_AW-1:0] addr,
   input  logic [mdp_pkg::DATA_W-1:0] wr_data,
   output logic [mdp_pkg::DATA_W-1:0] rd_data
);

   logic [mdp_pkg::DATA_W-1:0]    mem_ff [mdp_pkg::MEM_WORDS];
   logic [mdp_pkg::MEM_WORDS-1:0] valid_ff;
   logic [mdp_pkg::DATA_W-1:0]    rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[addr] ? mem_ff[addr] : '0;
      end
   end

   // valid bits stand in for clearing the array at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/microinstruction_datapath_step.sv
// Throughput: one item per cycle unless an untaken result stalls the item in the input register.
// Each item takes one pass through the ALU, shifter and memory port; its result is then registered.
// A read puts the memory word in a read register; MDR takes it from there for the next item.
// Reset: synchronous; registers, MBR and handshakes clear at once, memory reads zero until written.
// No clearing pass is needed: per-entry valid bits cover the memory reset.
module microinstruction_datapath_step (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // shift_left8, shift_right1, func[1:0], enable_a, enable_b, invert_a, carry_in,
   // c_write_mask[8:0], mem_write, mem_read, b_select[3:0], pad
   input  logic [mdp_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // shifter_out[31:0], carry_out, negative_flag, zero_flag, bus_b[31:0],
   // mdr_after[31:0], mar_after[31:0], addr_error, pad
   output logic [mdp_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_wr_en,
   input  logic [mdp_pkg::MBR_W-1:0]   csr_wr_data
);

   localparam int DW = mdp_pkg::DATA_W;

   // input register
   logic                 in_valid_ff;
   logic                 in_valid_in;
   mdp_pkg::uinstr_type  in_data_ff;
   logic                 req_take;
   logic                 exec;

   // datapath state
   logic [DW-1:0]           regs_ff [mdp_pkg::NUM_REGS];
   logic [DW-1:0]           regs_in [mdp_pkg::NUM_REGS];
   logic                    mdr_pend_ff;
   logic [mdp_pkg::MBR_W-1:0] mbr_ff;

   // execute
   logic [DW-1:0]        mem_rd_data;
   logic [DW-1:0]        mdr_cur;
   logic [DW-1:0]        bus_b;
   logic [DW-1:0]        mar_new;
   mdp_pkg::alu_res_type alu_res;
   logic                 access;
   logic                 addr_ok;
   logic                 mem_rd;
   logic                 mem_wr;
   logic                 err;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   mdp_pkg::alu_res_type out_alu_ff;
   logic [DW-1:0]        out_bus_b_ff;
   logic [DW-1:0]        out_mdr_ff;
   logic [DW-1:0]        out_mar_ff;
   logic                 out_err_ff;
   logic                 out_mdr_mem_ff;
   logic [DW-1:0]        mdr_after;

   assign exec        = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || exec;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !exec);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= mdp_pkg::uinstr_type'(req_tdata[$bits(mdp_pkg::uinstr_type)-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mbr_ff <= '0;
      end else if (csr_wr_en) begin
         mbr_ff <= csr_wr_data;
      end
   end

   // MDR lives in the memory read register after a load
   assign mdr_cur = mdr_pend_ff ? mem_rd_data : regs_ff[mdp_pkg::REG_MDR];

   always_comb begin
      case (mdp_pkg::bsel_type'(in_data_ff.b_select))
         mdp_pkg::BSEL_MDR:    bus_b = mdr_cur;
         mdp_pkg::BSEL_PC:     bus_b = regs_ff[mdp_pkg::REG_PC];
         mdp_pkg::BSEL_MBR_SX: bus_b = {{(DW-mdp_pkg::MBR_W){mbr_ff[mdp_pkg::MBR_W-1]}}, mbr_ff};
         mdp_pkg::BSEL_MBR_ZX: bus_b = {{(DW-mdp_pkg::MBR_W){1'b0}}, mbr_ff};
         mdp_pkg::BSEL_SP:     bus_b = regs_ff[mdp_pkg::REG_SP];
         mdp_pkg::BSEL_LV:     bus_b = regs_ff[mdp_pkg::REG_LV];
         mdp_pkg::BSEL_CPP:    bus_b = regs_ff[mdp_pkg::REG_CPP];
         mdp_pkg::BSEL_TOS:    bus_b = regs_ff[mdp_pkg::REG_TOS];
         default:              bus_b = regs_ff[mdp_pkg::REG_OPC];
      endcase
   end

   mdp_alu u_alu (
      .ctl   (in_data_ff),
      .a_bus (regs_ff[mdp_pkg::REG_H]),
      .b_bus (bus_b),
      .res   (alu_res)
   );

   always_comb begin
      for (int i = 0; i < mdp_pkg::NUM_REGS; i++) begin
         if (in_data_ff.c_write_mask[i]) begin
            regs_in[i] = alu_res.shifter_out;
         end else if (i == mdp_pkg::REG_MDR) begin
            regs_in[i] = mdr_cur;
         end else begin
            regs_in[i] = regs_ff[i];
         end
      end
   end

   assign mar_new = regs_in[mdp_pkg::REG_MAR];
   assign addr_ok = !mar_new[DW-1] && (mar_new < DW'(mdp_pkg::MEM_WORDS));
   assign access  = in_data_ff.mem_read ^ in_data_ff.mem_write;
   assign mem_rd  = exec && access && in_data_ff.mem_read && addr_ok;
   assign mem_wr  = exec && access && in_data_ff.mem_write && addr_ok;
   assign err     = access && !addr_ok;

   mdp_dmem u_dmem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr),
      .rd_en   (mem_rd),
      .addr    (mar_new[mdp_pkg::MEM_AW-1:0]),
      .wr_data (regs_in[mdp_pkg::REG_MDR]),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mdp_pkg::NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
         mdr_pend_ff <= 1'b0;
      end else if (exec) begin
         for (int i = 0; i < mdp_pkg::NUM_REGS; i++) begin
            regs_ff[i] <= regs_in[i];
         end
         mdr_pend_ff <= mem_rd;
      end
   end

   assign rsp_valid_in = exec || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         out_alu_ff     <= alu_res;
         out_bus_b_ff   <= bus_b;
         out_mdr_ff     <= regs_in[mdp_pkg::REG_MDR];
         out_mar_ff     <= mar_new;
         out_err_ff     <= err;
         out_mdr_mem_ff <= mem_rd;
      end
   end

   // the read register holds until the next load, which only happens once this item is taken
   assign mdr_after = out_mdr_mem_ff ? mem_rd_data : out_mdr_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, out_err_ff, out_mar_ff, mdr_after, out_bus_b_ff,
                        out_alu_ff.zero, out_alu_ff.negative, out_alu_ff.carry_out,
                        out_alu_ff.shifter_out};

endmodule

### bench/microinstruction_datapath_step_tb.sv
// Self-checking bench for the microinstruction datapath step: directed and random microcode.
`timescale 1ns / 100ps

module microinstruction_datapath_step_tb;

   localparam int QUIET_LIMIT = 1000;
   localparam int CHUNKS      = 6;
   localparam int CHUNK_ITEMS = 150;
   // B select codes 8 to 15 all land on OPC
   localparam logic [3:0] BSEL_OPC_FIRST = 4'd8;
   localparam logic [3:0] BSEL_OPC_LAST  = 4'd15;

   // laid out as on rsp_tdata, lowest field last
   typedef struct packed {
      logic        addr_error;
      logic [31:0] mar_after;
      logic [31:0] mdr_after;
      logic [31:0] bus_b;
      logic        zero;
      logic        negative;
      logic        carry;
      logic [31:0] shifter_out;
   } step_result_type;

   localparam int RESULT_W = $bits(step_result_type);

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        req_tvalid  = 1'b0;
   logic                        req_tready;
   logic [mdp_pkg::REQ_W-1:0]   req_tdata   = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready  = 1'b0;
   logic [mdp_pkg::RSP_W-1:0]   rsp_tdata;
   logic                        csr_wr_en   = 1'b0;
   logic [mdp_pkg::MBR_W-1:0]   csr_wr_data = '0;

   // datapath state as the bench sees it
   logic [mdp_pkg::DATA_W-1:0]  reg_file [mdp_pkg::NUM_REGS]  = '{default: '0};
   logic [mdp_pkg::DATA_W-1:0]  data_mem [mdp_pkg::MEM_WORDS] = '{default: '0};
   logic [mdp_pkg::MBR_W-1:0]   mbr_setting = '0;

   mdp_pkg::uinstr_type pending_uinstrs [$];
   step_result_type     expected_results [$];
   mdp_pkg::uinstr_type in_flight;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  mismatches    = 0;
   int                  quiet_cycles  = 0;

   microinstruction_datapath_step u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // runs one microinstruction on the bench's copy of the datapath
   function automatic step_result_type execute_uinstr(mdp_pkg::uinstr_type u);
      step_result_type            r;
      logic [mdp_pkg::DATA_W-1:0] a_op, b_op, c_bus, mar;
      logic [mdp_pkg::DATA_W:0]   total;
      r = '0;
      case (u.b_select)
         mdp_pkg::BSEL_MDR:    r.bus_b = reg_file[mdp_pkg::REG_MDR];
         mdp_pkg::BSEL_PC:     r.bus_b = reg_file[mdp_pkg::REG_PC];
         mdp_pkg::BSEL_MBR_SX: r.bus_b = {{(mdp_pkg::DATA_W-mdp_pkg::MBR_W){
                                          mbr_setting[mdp_pkg::MBR_W-1]}}, mbr_setting};
         mdp_pkg::BSEL_MBR_ZX: r.bus_b = {{(mdp_pkg::DATA_W-mdp_pkg::MBR_W){1'b0}},
                                          mbr_setting};
         mdp_pkg::BSEL_SP:     r.bus_b = reg_file[mdp_pkg::REG_SP];
         mdp_pkg::BSEL_LV:     r.bus_b = reg_file[mdp_pkg::REG_LV];
         mdp_pkg::BSEL_CPP:    r.bus_b = reg_file[mdp_pkg::REG_CPP];
         mdp_pkg::BSEL_TOS:    r.bus_b = reg_file[mdp_pkg::REG_TOS];
         default:              r.bus_b = reg_file[mdp_pkg::REG_OPC];
      endcase
      a_op = u.enable_a ? (u.invert_a ? ~reg_file[mdp_pkg::REG_H] : reg_file[mdp_pkg::REG_H])
                        : '0;
      b_op = u.enable_b ? r.bus_b : '0;
      case (u.func)
         mdp_pkg::FUNC_AND:  c_bus = a_op & b_op;
         mdp_pkg::FUNC_OR:   c_bus = a_op | b_op;
         mdp_pkg::FUNC_NOTB: c_bus = ~b_op;
         default: begin
            total   = {1'b0, a_op} + {1'b0, b_op} + {{mdp_pkg::DATA_W{1'b0}}, u.carry_in};
            c_bus   = total[mdp_pkg::DATA_W-1:0];
            r.carry = total[mdp_pkg::DATA_W];
         end
      endcase
      if (u.shift_left8)
         c_bus = {c_bus[mdp_pkg::DATA_W-9:0], 8'd0};
      if (u.shift_right1)
         c_bus = {c_bus[mdp_pkg::DATA_W-1], c_bus[mdp_pkg::DATA_W-1:1]};
      for (int i = 0; i < mdp_pkg::NUM_REGS; i++)
         if (u.c_write_mask[i])
            reg_file[i] = c_bus;
      // memory sees MAR and MDR after the C-bus write
      mar = reg_file[mdp_pkg::REG_MAR];
      if (u.mem_read != u.mem_write) begin
         if (!mar[mdp_pkg::DATA_W-1] && mar < mdp_pkg::MEM_WORDS) begin
            if (u.mem_read)
               reg_file[mdp_pkg::REG_MDR] = data_mem[mar[mdp_pkg::MEM_AW-1:0]];
            else
               data_mem[mar[mdp_pkg::MEM_AW-1:0]] = reg_file[mdp_pkg::REG_MDR];
         end else begin
            r.addr_error = 1'b1;
         end
      end
      r.shifter_out = c_bus;
      r.negative    = c_bus[mdp_pkg::DATA_W-1];
      r.zero        = (c_bus == '0);
      r.mdr_after   = reg_file[mdp_pkg::REG_MDR];
      r.mar_after   = mar;
      return r;
   endfunction

   function automatic mdp_pkg::uinstr_type uop(mdp_pkg::alu_func_type func, logic [3:0] bsel,
                                               bit ena, bit enb, bit inva, bit cin,
                                               bit sl8, bit sr1, logic [8:0] mask,
                                               bit wr, bit rd);
      mdp_pkg::uinstr_type u;
      u.func         = func;
      u.b_select     = bsel;
      u.enable_a     = ena;
      u.enable_b     = enb;
      u.invert_a     = inva;
      u.carry_in     = cin;
      u.shift_left8  = sl8;
      u.shift_right1 = sr1;
      u.c_write_mask = mask;
      u.mem_write    = wr;
      u.mem_read     = rd;
      return u;
   endfunction

   // appends an item to the tail of the pending queue
   function automatic void add_uinstr(mdp_pkg::uinstr_type u);
      pending_uinstrs.insert(pending_uinstrs.size(), u);
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endfunction

   // mostly address-then-access runs with random content, the rest raw noise
   task automatic queue_random_uinstrs(int count);
      mdp_pkg::uinstr_type u;
      logic [31:0]         raw;
      int                  added;
      added = 0;
      while (added < count) begin
         raw = $urandom;
         u   = raw[$bits(mdp_pkg::uinstr_type)-1:0];
         if ($urandom_range(99) < 30) begin
            add_uinstr(u);
            added++;
         end else begin
            // MAR = H & MBR keeps the address inside what MBR allows
            u.func        = mdp_pkg::FUNC_AND;
            u.enable_a    = 1'b1;
            u.enable_b    = 1'b1;
            u.b_select    = mdp_pkg::BSEL_MBR_ZX;
            u.shift_left8 = 1'b0;
            u.c_write_mask[mdp_pkg::REG_MAR] = 1'b1;
            add_uinstr(u);
            added++;
            repeat ($urandom_range(1, 3)) begin
               raw = $urandom;
               u   = raw[$bits(mdp_pkg::uinstr_type)-1:0];
               u.c_write_mask[mdp_pkg::REG_MAR] = 1'b0;
               if ($urandom_range(99) < 80) begin
                  u.mem_read  = 1'($urandom_range(1));
                  u.mem_write = !u.mem_read;
               end
               add_uinstr(u);
               added++;
            end
         end
      end
   endtask

   // sampled on the falling edge, clear of the drivers
   task automatic wait_drained();
      @(negedge clock);
      while (pending_uinstrs.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_mbr(logic [mdp_pkg::MBR_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      mbr_setting = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   always @(posedge clock) begin : uinstr_driver
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.insert(expected_results.size(), execute_uinstr(in_flight));
         if (!req_tvalid || req_tready) begin
            offer = pending_uinstrs.size() != 0 && $urandom_range(99) >= send_idle_pct;
            if (offer) begin
               in_flight = pending_uinstrs.pop_front();
               req_tdata <= {{(mdp_pkg::REQ_W-$bits(mdp_pkg::uinstr_type)){1'b0}}, in_flight};
            end
            req_tvalid <= offer;
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      step_result_type want, got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result item with nothing outstanding: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               got  = rsp_tdata[RESULT_W-1:0];
               compare_field("shifter_out", want.shifter_out, got.shifter_out);
               compare_field("carry_out", want.carry, got.carry);
               compare_field("negative_flag", want.negative, got.negative);
               compare_field("zero_flag", want.zero, got.zero);
               compare_field("bus_b", want.bus_b, got.bus_b);
               compare_field("mdr_after", want.mdr_after, got.mdr_after);
               compare_field("mar_after", want.mar_after, got.mar_after);
               compare_field("addr_error", want.addr_error, got.addr_error);
            end
         end
         rsp_tready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      logic [3:0]                b_sources [7];
      logic [mdp_pkg::MBR_W-1:0] mbr_plan [CHUNKS];
      b_sources = '{mdp_pkg::BSEL_PC, mdp_pkg::BSEL_SP, mdp_pkg::BSEL_LV, mdp_pkg::BSEL_CPP,
                    mdp_pkg::BSEL_TOS, mdp_pkg::BSEL_MDR, BSEL_OPC_FIRST};
      mbr_plan  = '{8'hFF, 8'h00, 8'h7F, 8'h80, 8'hFF, 8'h00};
      mbr_plan[3] = (mdp_pkg::MBR_W)'($urandom);
      mbr_plan[5] = (mdp_pkg::MBR_W)'($urandom);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 29;
      recv_idle_pct = 60;
      write_mbr(8'h80);

      // H = all ones, then H + 1 with carry out
      add_uinstr(uop(mdp_pkg::FUNC_NOTB, mdp_pkg::BSEL_MDR, 0, 0, 0, 0, 0, 0, 9'h100, 0, 0));
      add_uinstr(uop(mdp_pkg::FUNC_ADD, mdp_pkg::BSEL_MDR, 1, 0, 0, 1, 0, 0, 9'h000, 0, 0));
      add_uinstr(uop(mdp_pkg::FUNC_ADD, mdp_pkg::BSEL_MBR_SX, 1, 1, 1, 0, 0, 0, 9'h080, 0, 0));
      add_uinstr(uop(mdp_pkg::FUNC_OR, mdp_pkg::BSEL_MBR_ZX, 1, 1, 0, 0, 0, 0, 9'h040, 0, 0));
      add_uinstr(uop(mdp_pkg::FUNC_AND, BSEL_OPC_LAST, 1, 1, 0, 0, 1, 0, 9'h008, 0, 0));
      // both shifts together, then a right shift on its own
      add_uinstr(uop(mdp_pkg::FUNC_OR, mdp_pkg::BSEL_MDR, 1, 0, 0, 0, 1, 1, 9'h010, 0, 0));
      add_uinstr(uop(mdp_pkg::FUNC_ADD, mdp_pkg::BSEL_SP, 1, 1, 0, 1, 0, 1, 9'h020, 0, 0));
      // MAR and PC take the MBR byte, then MDR = H is stored there
      add_uinstr(uop(mdp_pkg::FUNC_OR, mdp_pkg::BSEL_MBR_ZX, 0, 1, 0, 0, 0, 0, 9'h005, 0, 0));
      add_uinstr(uop(mdp_pkg::FUNC_OR, mdp_pkg::BSEL_MDR, 1, 0, 0, 0, 0, 0, 9'h002, 1, 0));
      // read with write: no access at all
      add_uinstr(uop(mdp_pkg::FUNC_AND, mdp_pkg::BSEL_MDR, 0, 0, 0, 0, 0, 0, 9'h000, 1, 1));
      add_uinstr(uop(mdp_pkg::FUNC_AND, mdp_pkg::BSEL_MDR, 0, 0, 0, 0, 0, 0, 9'h002, 0, 1));
      // read of a word never stored
      add_uinstr(uop(mdp_pkg::FUNC_OR, mdp_pkg::BSEL_MBR_ZX, 0, 1, 0, 0, 0, 1, 9'h001, 0, 1));
      add_uinstr(uop(mdp_pkg::FUNC_AND, mdp_pkg::BSEL_MDR, 0, 0, 0, 0, 0, 0, 9'h001, 1, 0));
      // negative MAR, then no access with MAR still out of range
      add_uinstr(uop(mdp_pkg::FUNC_OR, mdp_pkg::BSEL_MDR, 1, 0, 0, 0, 0, 0, 9'h001, 1, 0));
      add_uinstr(uop(mdp_pkg::FUNC_AND, mdp_pkg::BSEL_MDR, 0, 0, 0, 0, 0, 0, 9'h000, 0, 0));
      // MAR past the top of memory
      add_uinstr(uop(mdp_pkg::FUNC_OR, mdp_pkg::BSEL_MBR_ZX, 0, 1, 0, 0, 1, 0, 9'h001, 0, 1));
      foreach (b_sources[i])
         add_uinstr(uop(mdp_pkg::FUNC_OR, b_sources[i], 0, 1, 0, 0, 0, 0, 9'h000, 0, 0));
      add_uinstr(uop(mdp_pkg::FUNC_ADD, BSEL_OPC_LAST, 1, 1, 0, 1, 1, 1, 9'h1FF, 0, 0));
      wait_drained();

      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
         if (chunk < 2) begin
            send_idle_pct = 29;
            recv_idle_pct = 60;
         end else if (chunk < 4) begin
            send_idle_pct = 60;
            recv_idle_pct = 29;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_mbr(mbr_plan[chunk]);
         queue_random_uinstrs(CHUNK_ITEMS / 2);
         // sender holds off until every outstanding result is back
         wait_drained();
         queue_random_uinstrs(CHUNK_ITEMS / 2);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### sim.f
rtl/mdp_pkg.sv
rtl/mdp_alu.sv
rtl/mdp_dmem.sv
rtl/microinstruction_datapath_step.sv
bench/microinstruction_datapath_step_tb.sv
